@@ hdl/trzb_pkg.sv @@
// Shared types, codes and constants of the triangle rasterizer with depth buffer.
// Holds the gamma table builder used at elaboration. No dependencies.
`timescale 1ns / 1ps

package trzb_pkg;

  // Operation codes of an input transfer
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_PIX,
    S_MAC,
    S_DIV,
    S_ZTEST,
    S_GIDX,
    S_GROM,
    S_GPUT,
    S_WRITE,
    S_RD_ADDR,
    S_RD_MEM,
    S_RD_OUT
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_SETUP,
    OP_PIX,
    OP_MAC,
    OP_DIV,
    OP_ZTEST,
    OP_GIDX,
    OP_GROM,
    OP_GPUT,
    OP_WRITE,
    OP_CLEAR,
    OP_RD_ADDR,
    OP_RD_MEM
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] step;
    logic [1:0] chan;
  } dp_cmd_t;

  typedef struct packed {
    logic covered;
    logic zpass;
    logic last;
    logic draw_ok;
    logic clr_last;
  } dp_status_t;

  localparam logic [1:0]  LAST_CORNER = 2'd2;
  localparam logic [3:0]  SETUP_LAST  = 4'd9;
  localparam logic [3:0]  MAC_LAST    = 4'd3;
  localparam logic [3:0]  DIV_LAST    = 4'd15;
  localparam logic [1:0]  CH_DEPTH    = 2'd0;
  localparam logic [1:0]  CH_RED      = 2'd1;
  localparam logic [1:0]  CH_GREEN    = 2'd2;
  localparam logic [1:0]  CH_BLUE     = 2'd3;
  localparam logic [15:0] FAR_DEPTH   = 16'hFFFF;

  // Gamma code of table entry idx out of m: largest k in 0..255 with
  // (2k-1)^11 * m^5 <= idx^5 * 510^11, found by binary search.
  function automatic logic [7:0] gamma_code(input int unsigned idx, input int unsigned m);
    logic [191:0] rhs;
    logic [191:0] lhs;
    logic [8:0]   k;
    logic [8:0]   t;
    rhs = 192'd1;
    k   = 9'd0;
    for (int j = 0; j < 5; j++) rhs = rhs * 192'(idx);
    for (int j = 0; j < 11; j++) rhs = rhs * 192'd510;
    for (int b = 7; b >= 0; b--) begin
      t   = k | (9'd1 << b);
      lhs = 192'd1;
      for (int j = 0; j < 11; j++) lhs = lhs * 192'(2 * t - 9'd1);
      for (int j = 0; j < 5; j++) lhs = lhs * 192'(m);
      if (lhs <= rhs) k = t;
    end
    return k[7:0];
  endfunction

endpackage

@@ hdl/trzb_ctrl.sv @@
// Sequencer of the rasterizer: state machine, step and channel counters.
// Depends on trzb_pkg; drives trzb_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module trzb_ctrl import trzb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] func_i,
  input  logic [1:0] corner_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy,
  output logic       result_valid_o
);

  ctl_state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] ch_q, ch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      ch_q    <= CH_DEPTH;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ch_q    <= ch_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    ch_d    = ch_q;
    unique case (state_q)
      S_CLEAR: if (status_i.clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (func_i)
            FUNC_LOAD:  if (corner_i == LAST_CORNER) state_d = S_SETUP;
            FUNC_READ:  state_d = S_RD_ADDR;
            FUNC_CLEAR: state_d = S_CLEAR;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SETUP: begin
        if (cnt_q != SETUP_LAST) begin
          cnt_d = cnt_q + 4'd1;
        end else begin
          state_d = status_i.draw_ok ? S_PIX : S_IDLE;
        end
      end
      S_PIX: begin
        if (status_i.covered) begin
          state_d = S_MAC;
          ch_d    = CH_DEPTH;
        end else if (status_i.last) begin
          state_d = S_IDLE;
        end
      end
      S_MAC: begin
        if (cnt_q == MAC_LAST) state_d = S_DIV;
        else cnt_d = cnt_q + 4'd1;
      end
      S_DIV: begin
        if (cnt_q == DIV_LAST) state_d = (ch_q == CH_DEPTH) ? S_ZTEST : S_GIDX;
        else cnt_d = cnt_q + 4'd1;
      end
      S_ZTEST: begin
        if (status_i.zpass) begin
          state_d = S_MAC;
          ch_d    = CH_RED;
        end else begin
          state_d = status_i.last ? S_IDLE : S_PIX;
        end
      end
      S_GIDX: state_d = S_GROM;
      S_GROM: state_d = S_GPUT;
      S_GPUT: begin
        if (ch_q == CH_BLUE) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_MAC;
          ch_d    = ch_q + 2'd1;
        end
      end
      S_WRITE:   state_d = status_i.last ? S_IDLE : S_PIX;
      S_RD_ADDR: state_d = S_RD_MEM;
      S_RD_MEM:  state_d = S_RD_OUT;
      S_RD_OUT:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.step = cnt_q;
    cmd_o.chan = ch_q;
    unique case (state_q)
      S_CLEAR:   cmd_o.op = OP_CLEAR;
      S_IDLE:    cmd_o.op = start ? OP_ACCEPT : OP_IDLE;
      S_SETUP:   cmd_o.op = OP_SETUP;
      S_PIX:     cmd_o.op = OP_PIX;
      S_MAC:     cmd_o.op = OP_MAC;
      S_DIV:     cmd_o.op = OP_DIV;
      S_ZTEST:   cmd_o.op = OP_ZTEST;
      S_GIDX:    cmd_o.op = OP_GIDX;
      S_GROM:    cmd_o.op = OP_GROM;
      S_GPUT:    cmd_o.op = OP_GPUT;
      S_WRITE:   cmd_o.op = OP_WRITE;
      S_RD_ADDR: cmd_o.op = OP_RD_ADDR;
      S_RD_MEM:  cmd_o.op = OP_RD_MEM;
      default:   cmd_o.op = OP_IDLE;
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RD_OUT);

endmodule

@@ hdl/trzb_datapath.sv @@
// Datapath of the rasterizer: corner registers, edge walkers, shared multiplier,
// serial divider, gamma table and the pixel store. Depends on trzb_pkg.
`timescale 1ns / 1ps

module trzb_datapath import trzb_pkg::*; #(
  parameter int IMAGE_WIDTH      = 512,
  parameter int IMAGE_HEIGHT     = 512,
  parameter int GAMMA_INDEX_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic [1:0]         func_i,
  input  logic [1:0]         corner_i,
  input  logic signed [11:0] vert_x_i,
  input  logic signed [11:0] vert_y_i,
  input  logic [15:0]        vert_depth_i,
  input  logic [11:0]        vert_red_i,
  input  logic [11:0]        vert_green_i,
  input  logic [11:0]        vert_blue_i,
  input  logic [8:0]         read_col_i,
  input  logic [8:0]         read_row_i,
  output logic [7:0]         pix_red_o,
  output logic [7:0]         pix_green_o,
  output logic [7:0]         pix_blue_o,
  output logic [15:0]        pix_depth_o
);

  localparam int NPIX  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW    = $clog2(NPIX);
  localparam int GSIZE = 1 << GAMMA_INDEX_BITS;
  localparam int GMAX  = GSIZE - 1;
  localparam int TW    = GAMMA_INDEX_BITS + 12;

  // Corner registers
  logic signed [11:0] cx_q [3];
  logic signed [11:0] cy_q [3];
  logic [15:0]        cd_q [3];
  logic [11:0]        cr_q [3];
  logic [11:0]        cg_q [3];
  logic [11:0]        cb_q [3];

  // Walker and arithmetic state
  logic [10:0]        minx_q, maxx_q, miny_q, maxy_q, x_q, y_q;
  logic               empty_q;
  logic signed [27:0] area_q;
  logic signed [27:0] w_q   [3];
  logic signed [27:0] row_q [3];
  logic signed [13:0] dx_q  [3];
  logic signed [13:0] dy_q  [3];
  logic [AW-1:0]      row_base_q, clr_addr_q, pix_addr, rd_addr;
  logic signed [44:0] prod_q, acc_q, prod_d, diff, num;
  logic signed [27:0] mul_a;
  logic signed [16:0] mul_b;
  logic [27:0]        rem_q;
  logic [15:0]        nq_q, depth_q;
  logic [23:0]        rgb_q;
  logic [GAMMA_INDEX_BITS-1:0] gidx_q;
  logic [7:0]         gam_q;
  logic [8:0]         col_q, row_rd_q;
  logic               oor_q;
  logic [39:0]        rd_q;

  // Edge geometry
  logic signed [13:0] sx [3];
  logic signed [13:0] sy [3];
  logic signed [13:0] edx [3];
  logic signed [13:0] edy [3];
  logic signed [13:0] mnx, mxx, mny, mxy, minx_c, maxx_c, miny_c, maxy_c, minx_s, miny_s;
  logic signed [13:0] d_a, d_b;
  logic [15:0]        va [3];
  logic               adv, neg;
  logic [28:0]        r2;
  logic               ge;
  logic [10:0]        cc;
  logic [TW-1:0]      gt;

  for (genvar i = 0; i < 3; i++) begin : g_edge
    assign sx[i]  = {{2{cx_q[i][11]}}, cx_q[i]};
    assign sy[i]  = {{2{cy_q[i][11]}}, cy_q[i]};
    assign edx[i] = sy[i] - sy[(i + 1) % 3];
    assign edy[i] = sx[(i + 1) % 3] - sx[i];
  end

  function automatic logic signed [13:0] smin(input logic signed [13:0] a, input logic signed [13:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [13:0] smax(input logic signed [13:0] a, input logic signed [13:0] b);
    return (a > b) ? a : b;
  endfunction

  always_comb begin
    mnx    = smin(smin(sx[0], sx[1]), sx[2]);
    mxx    = smax(smax(sx[0], sx[1]), sx[2]);
    mny    = smin(smin(sy[0], sy[1]), sy[2]);
    mxy    = smax(smax(sy[0], sy[1]), sy[2]);
    minx_c = (mnx < 14'sd0) ? 14'sd0 : mnx;
    miny_c = (mny < 14'sd0) ? 14'sd0 : mny;
    maxx_c = (mxx > 14'(IMAGE_WIDTH - 1)) ? 14'(IMAGE_WIDTH - 1) : mxx;
    maxy_c = (mxy > 14'(IMAGE_HEIGHT - 1)) ? 14'(IMAGE_HEIGHT - 1) : mxy;
    minx_s = {3'b000, minx_q};
    miny_s = {3'b000, miny_q};
  end

  // Corner values of the channel being interpolated
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (cmd_i.chan)
        CH_DEPTH: va[i] = cd_q[i];
        CH_RED:   va[i] = {4'b0000, cr_q[i]};
        CH_GREEN: va[i] = {4'b0000, cg_q[i]};
        default:  va[i] = {4'b0000, cb_q[i]};
      endcase
    end
  end

  // Shared multiplier operands
  always_comb begin
    d_a   = '0;
    d_b   = '0;
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SETUP: begin
        case (cmd_i.step)
          4'd0: begin d_a = sx[1] - sx[0]; d_b = sy[2] - sy[0]; end
          4'd1: begin d_a = sx[2] - sx[0]; d_b = sy[1] - sy[0]; end
          4'd2: begin d_a = sx[1] - sx[0]; d_b = miny_s - sy[0]; end
          4'd3: begin d_a = minx_s - sx[0]; d_b = sy[1] - sy[0]; end
          4'd4: begin d_a = sx[2] - sx[1]; d_b = miny_s - sy[1]; end
          4'd5: begin d_a = minx_s - sx[1]; d_b = sy[2] - sy[1]; end
          4'd6: begin d_a = sx[0] - sx[2]; d_b = miny_s - sy[2]; end
          4'd7: begin d_a = minx_s - sx[2]; d_b = sy[0] - sy[2]; end
          4'd8: begin d_a = miny_s; d_b = 14'(IMAGE_WIDTH); end
          default: begin d_a = '0; d_b = '0; end
        endcase
        mul_a = {{14{d_a[13]}}, d_a};
        mul_b = {{3{d_b[13]}}, d_b};
      end
      OP_MAC: begin
        case (cmd_i.step)
          4'd0:    begin mul_a = w_q[1]; mul_b = {1'b0, va[0]}; end
          4'd1:    begin mul_a = w_q[2]; mul_b = {1'b0, va[1]}; end
          default: begin mul_a = w_q[0]; mul_b = {1'b0, va[2]}; end
        endcase
      end
      OP_RD_ADDR: begin
        mul_a = {19'b0, row_rd_q};
        mul_b = 17'(IMAGE_WIDTH);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign diff     = acc_q - prod_q;
  assign num      = acc_q + prod_q;
  assign r2       = {rem_q, nq_q[15]};
  assign ge       = (r2 >= {1'b0, area_q});
  assign neg      = area_q[27];
  assign cc       = (nq_q > 16'd1024) ? 11'd1024 : nq_q[10:0];
  assign gt       = {1'b0, cc, {GAMMA_INDEX_BITS{1'b0}}} - TW'(cc) + TW'(512);
  assign pix_addr = row_base_q + AW'(x_q);
  assign rd_addr  = prod_q[AW-1:0] + AW'(col_q);

  assign status_o.covered  = !w_q[0][27] && !w_q[1][27] && !w_q[2][27];
  assign status_o.zpass    = (nq_q < rd_q[39:24]);
  assign status_o.last     = (x_q == maxx_q) && (y_q == maxy_q);
  assign status_o.draw_ok  = (area_q != '0) && !empty_q;
  assign status_o.clr_last = (clr_addr_q == AW'(NPIX - 1));

  assign adv = ((cmd_i.op == OP_PIX) && !status_o.covered)
            || ((cmd_i.op == OP_ZTEST) && !status_o.zpass)
            || (cmd_i.op == OP_WRITE);

  // Corner registers and clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cx_q[i] <= '0;
        cy_q[i] <= '0;
        cd_q[i] <= '0;
        cr_q[i] <= '0;
        cg_q[i] <= '0;
        cb_q[i] <= '0;
      end
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.op == OP_ACCEPT) begin
        clr_addr_q <= '0;
        if (func_i == FUNC_LOAD && corner_i <= LAST_CORNER) begin
          cx_q[corner_i] <= vert_x_i;
          cy_q[corner_i] <= vert_y_i;
          cd_q[corner_i] <= vert_depth_i;
          cr_q[corner_i] <= vert_red_i;
          cg_q[corner_i] <= vert_green_i;
          cb_q[corner_i] <= vert_blue_i;
        end
      end else if (cmd_i.op == OP_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // Arithmetic and walker registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      OP_ACCEPT: begin
        col_q    <= read_col_i;
        row_rd_q <= read_row_i;
      end
      OP_SETUP: begin
        case (cmd_i.step)
          4'd0: begin
            minx_q  <= minx_c[10:0];
            maxx_q  <= maxx_c[10:0];
            miny_q  <= miny_c[10:0];
            maxy_q  <= maxy_c[10:0];
            empty_q <= (minx_c > maxx_c) || (miny_c > maxy_c);
          end
          4'd2: area_q <= diff[27:0];
          4'd4: w_q[0] <= diff[27:0];
          4'd6: w_q[1] <= diff[27:0];
          4'd8: w_q[2] <= diff[27:0];
          4'd9: begin
            // make the winding positive, start at the top-left corner of the box
            area_q     <= neg ? -area_q : area_q;
            x_q        <= minx_q;
            y_q        <= miny_q;
            row_base_q <= prod_q[AW-1:0];
            for (int i = 0; i < 3; i++) begin
              w_q[i]   <= neg ? -w_q[i] : w_q[i];
              row_q[i] <= neg ? -w_q[i] : w_q[i];
              dx_q[i]  <= neg ? -edx[i] : edx[i];
              dy_q[i]  <= neg ? -edy[i] : edy[i];
            end
          end
          default: acc_q <= prod_q;
        endcase
      end
      OP_MAC: begin
        case (cmd_i.step)
          4'd1: acc_q <= prod_q + {18'b0, area_q[27:1]};
          4'd2: acc_q <= num;
          4'd3: begin
            rem_q <= num[43:16];
            nq_q  <= num[15:0];
          end
          default: acc_q <= acc_q;
        endcase
      end
      OP_DIV: begin
        rem_q <= ge ? 28'(r2 - {1'b0, area_q}) : r2[27:0];
        nq_q  <= {nq_q[14:0], ge};
      end
      OP_ZTEST: depth_q <= nq_q;
      OP_GIDX:  gidx_q <= gt[10 +: GAMMA_INDEX_BITS];
      OP_GPUT: begin
        case (cmd_i.chan)
          CH_RED:   rgb_q[23:16] <= gam_q;
          CH_GREEN: rgb_q[15:8]  <= gam_q;
          default:  rgb_q[7:0]   <= gam_q;
        endcase
      end
      OP_RD_ADDR: oor_q <= (32'(col_q) >= IMAGE_WIDTH) || (32'(row_rd_q) >= IMAGE_HEIGHT);
      default: acc_q <= acc_q;
    endcase

    // step the walker to the next pixel of the box
    if (adv && !status_o.last) begin
      if (x_q == maxx_q) begin
        x_q        <= minx_q;
        y_q        <= y_q + 11'd1;
        row_base_q <= row_base_q + AW'(IMAGE_WIDTH);
        for (int i = 0; i < 3; i++) begin
          row_q[i] <= row_q[i] + {{14{dy_q[i][13]}}, dy_q[i]};
          w_q[i]   <= row_q[i] + {{14{dy_q[i][13]}}, dy_q[i]};
        end
      end else begin
        x_q <= x_q + 11'd1;
        for (int i = 0; i < 3; i++) begin
          w_q[i] <= w_q[i] + {{14{dx_q[i][13]}}, dx_q[i]};
        end
      end
    end
  end

  // Gamma table, built at elaboration, registered read
  logic [7:0] gamma_rom [GSIZE];
  for (genvar gi = 0; gi < GSIZE; gi++) begin : g_gamma
    localparam logic [7:0] GV = gamma_code(gi, GMAX);
    assign gamma_rom[gi] = GV;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_GROM) gam_q <= gamma_rom[gidx_q];
  end

  // Pixel store: depth in the top 16 bits, red/green/blue below
  logic [39:0] pix_mem [NPIX];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR) begin
      pix_mem[clr_addr_q] <= {FAR_DEPTH, 24'h000000};
    end else if (cmd_i.op == OP_WRITE) begin
      pix_mem[pix_addr] <= {depth_q, rgb_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RD_MEM) begin
      rd_q <= pix_mem[rd_addr];
    end else if (cmd_i.op == OP_PIX && status_o.covered) begin
      rd_q <= pix_mem[pix_addr];
    end
  end

  assign pix_red_o   = oor_q ? 8'h00 : rd_q[23:16];
  assign pix_green_o = oor_q ? 8'h00 : rd_q[15:8];
  assign pix_blue_o  = oor_q ? 8'h00 : rd_q[7:0];
  assign pix_depth_o = oor_q ? FAR_DEPTH : rd_q[39:24];

endmodule

@@ hdl/triangle_raster_zbuffer_core.sv @@
// Top level of the triangle rasterizer with Gouraud shading and depth buffer.
// Instantiates trzb_ctrl and trzb_datapath; depends on trzb_pkg.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                   Payload
// command   in         start & !busy -> transfer   func, corner, vertex, read_col/row
// result    out        result_valid_o, one cycle   pix_red/green/blue, pix_depth
//
// A vertex load of corner 0 or 1 only stores that corner. Corner 2 runs the
// setup, then walks the clipped bounding box one pixel per cycle for
// uncovered pixels; a covered pixel runs a multiply-accumulate and a 16-step
// serial divider for the depth and, if it passes, a multiply-accumulate,
// divide and gamma lookup for each of three colours, then the write. A
// readback registers its address, reads the store and then shows its result.
// Reset and every clear item sweep the pixel store one entry per cycle,
// IMAGE_WIDTH*IMAGE_HEIGHT entries, with busy high. The receiver cannot stall.

module triangle_raster_zbuffer_core import trzb_pkg::*; #(
  parameter int IMAGE_WIDTH      = 512,
  parameter int IMAGE_HEIGHT     = 512,
  parameter int GAMMA_INDEX_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [1:0]         corner_i,
  input  logic signed [11:0] vert_x_i,
  input  logic signed [11:0] vert_y_i,
  input  logic [15:0]        vert_depth_i,
  input  logic [11:0]        vert_red_i,
  input  logic [11:0]        vert_green_i,
  input  logic [11:0]        vert_blue_i,
  input  logic [8:0]         read_col_i,
  input  logic [8:0]         read_row_i,
  output logic               result_valid_o,
  output logic [7:0]         pix_red_o,
  output logic [7:0]         pix_green_o,
  output logic [7:0]         pix_blue_o,
  output logic [15:0]        pix_depth_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: decodes the transfer and steps setup, walk, divide and gamma
  trzb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .func_i         (func_i),
    .corner_i       (corner_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // Datapath: edge functions, interpolation, gamma and the pixel store
  trzb_datapath #(
    .IMAGE_WIDTH      (IMAGE_WIDTH),
    .IMAGE_HEIGHT     (IMAGE_HEIGHT),
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (func_i),
    .corner_i     (corner_i),
    .vert_x_i     (vert_x_i),
    .vert_y_i     (vert_y_i),
    .vert_depth_i (vert_depth_i),
    .vert_red_i   (vert_red_i),
    .vert_green_i (vert_green_i),
    .vert_blue_i  (vert_blue_i),
    .read_col_i   (read_col_i),
    .read_row_i   (read_row_i),
    .pix_red_o    (pix_red_o),
    .pix_green_o  (pix_green_o),
    .pix_blue_o   (pix_blue_o),
    .pix_depth_o  (pix_depth_o)
  );

  // A result only appears while a readback holds the block busy
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe outside a readback");

  // A readback transfer yields its result after the address and memory read states
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_READ) |-> ##3 result_valid_o)
    else $error("readback result missing");

  // The result strobe lasts one cycle
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held");

  // A clear transfer starts the store sweep
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_CLEAR) |=> busy)
    else $error("clear did not start");

endmodule
